// ===== sv/tfpf_pkg.sv =====
// Shared types and constants for the target frame parser and filter.
package tfpf_pkg;

  localparam int unsigned FrameDataLen = 6;
  localparam int unsigned CfgIndexW    = 3;
  localparam int unsigned CfgDataW     = 11;
  localparam int unsigned LimitW       = 11;
  localparam int unsigned PosW         = 10;
  localparam int unsigned VelW         = 12;
  localparam int unsigned OutDataW     = 56;

  localparam logic [7:0]        HeaderReset = 8'hAA;
  localparam logic [7:0]        TailReset   = 8'hBB;
  localparam logic [7:0]        FoundReset  = 8'h55;
  localparam logic [LimitW-1:0] XLimitReset = 11'd640;
  localparam logic [LimitW-1:0] YLimitReset = 11'd480;
  localparam logic [LimitW-1:0] LimitCap    = 11'd1024;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_ACCEPT   = 2'd1,
    ST_BAD_TAIL = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic [CfgIndexW-1:0] {
    REG_HEADER  = 3'd0,
    REG_TAIL    = 3'd1,
    REG_FOUND   = 3'd2,
    REG_X_LIMIT = 3'd3,
    REG_Y_LIMIT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]        header_byte;
    logic [7:0]        tail_byte;
    logic [7:0]        found_code;
    logic [LimitW-1:0] x_limit;
    logic [LimitW-1:0] y_limit;
  } cfg_t;

  typedef struct packed {
    logic        done;
    logic        tail_ok;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
    logic [7:0]  code;
    logic [7:0]  beat;
  } frame_t;

  typedef struct packed {
    status_t                status;
    logic [PosW-1:0]        pos_x;
    logic [PosW-1:0]        pos_y;
    logic signed [VelW-1:0] vel_x;
    logic signed [VelW-1:0] vel_y;
    logic                   found;
    logic [7:0]             beat;
  } result_t;

endpackage

// ===== sv/tfpf_parser.sv =====
// Header hunt and frame byte collection.
module tfpf_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [7:0]       byte_in,
  input  tfpf_pkg::cfg_t   cfg,
  output tfpf_pkg::frame_t frame
);

  localparam logic [2:0] LastIdx = 3'(tfpf_pkg::FrameDataLen);

  logic       in_frame_r, in_frame_nxt;
  logic [2:0] byte_idx_r, byte_idx_nxt;
  logic [7:0] frame_bytes_r [tfpf_pkg::FrameDataLen];

  always_comb begin
    in_frame_nxt = in_frame_r;
    byte_idx_nxt = byte_idx_r;
    if (!in_frame_r) begin
      if (byte_in == cfg.header_byte) begin
        in_frame_nxt = 1'b1;
        byte_idx_nxt = '0;
      end
    end else if (byte_idx_r < LastIdx) begin
      byte_idx_nxt = byte_idx_r + 3'd1;
    end else begin
      in_frame_nxt = 1'b0;
      byte_idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      byte_idx_r <= '0;
    end else if (advance) begin
      in_frame_r <= in_frame_nxt;
      byte_idx_r <= byte_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_frame_r && byte_idx_r < LastIdx) begin
      frame_bytes_r[byte_idx_r] <= byte_in;
    end
  end

  always_comb begin
    frame.done    = in_frame_r && (byte_idx_r == LastIdx);
    frame.tail_ok = (byte_in == cfg.tail_byte);
    frame.raw_x   = {frame_bytes_r[1], frame_bytes_r[0]};
    frame.raw_y   = {frame_bytes_r[3], frame_bytes_r[2]};
    frame.code    = frame_bytes_r[4];
    frame.beat    = frame_bytes_r[5];
  end

endmodule

// ===== sv/tfpf_filter.sv =====
// Frame checks, position averaging and velocity smoothing with result state.
module tfpf_filter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  tfpf_pkg::frame_t  frame,
  input  tfpf_pkg::cfg_t    cfg,
  output tfpf_pkg::result_t result
);

  localparam int unsigned PosW     = tfpf_pkg::PosW;
  localparam int unsigned VelW     = tfpf_pkg::VelW;
  localparam int unsigned NumW     = VelW + 3;
  localparam int unsigned MagW     = NumW - 1;
  localparam int unsigned Div5Sh   = 14;
  localparam int unsigned ProdW    = MagW + VelW;
  localparam logic [ProdW-1:0] Div5Mul = ProdW'(3277);

  function automatic logic signed [VelW-1:0] next_speed(
    input logic signed [VelW-1:0] vel,
    input logic [PosW-1:0]        newp,
    input logic [PosW-1:0]        oldp
  );
    logic signed [VelW-1:0] d;
    logic signed [NumW-1:0] num;
    logic                   neg;
    logic [MagW-1:0]        mag;
    logic [ProdW-1:0]       prod;
    logic [VelW-1:0]        q;
    d    = $signed({2'b00, newp}) - $signed({2'b00, oldp});
    num  = $signed({vel[VelW-1], vel, 2'b00}) + NumW'(d);
    neg  = num[NumW-1];
    mag  = neg ? MagW'(-num) : MagW'(num);
    prod = ProdW'(mag) * Div5Mul;
    q    = prod[Div5Sh +: VelW];
    return neg ? $signed(-q) : $signed(q);
  endfunction

  tfpf_pkg::status_t      status_r, status_nxt;
  logic [PosW-1:0]        pos_x_r, pos_y_r, pos_x_nxt, pos_y_nxt;
  logic signed [VelW-1:0] vel_x_r, vel_y_r, vel_x_nxt, vel_y_nxt;
  logic                   found_r, found_nxt;
  logic [7:0]             beat_r, beat_nxt;

  logic [tfpf_pkg::LimitW-1:0] x_lim, y_lim;
  logic                        range_ok;
  logic [PosW:0]               sum_x, sum_y;

  always_comb begin
    x_lim = (cfg.x_limit > tfpf_pkg::LimitCap) ? tfpf_pkg::LimitCap : cfg.x_limit;
    y_lim = (cfg.y_limit > tfpf_pkg::LimitCap) ? tfpf_pkg::LimitCap : cfg.y_limit;
    range_ok = (frame.raw_x != 16'd0) && (frame.raw_x < {5'b0, x_lim}) &&
               (frame.raw_y != 16'd0) && (frame.raw_y < {5'b0, y_lim});
    sum_x = {1'b0, pos_x_r} + {1'b0, frame.raw_x[PosW-1:0]};
    sum_y = {1'b0, pos_y_r} + {1'b0, frame.raw_y[PosW-1:0]};

    status_nxt = tfpf_pkg::ST_IDLE;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    vel_x_nxt  = vel_x_r;
    vel_y_nxt  = vel_y_r;
    found_nxt  = found_r;
    beat_nxt   = beat_r;
    if (frame.done) begin
      if (!frame.tail_ok) begin
        status_nxt = tfpf_pkg::ST_BAD_TAIL;
      end else if (!range_ok) begin
        status_nxt = tfpf_pkg::ST_RANGE;
      end else begin
        status_nxt = tfpf_pkg::ST_ACCEPT;
        pos_x_nxt  = sum_x[PosW:1];
        pos_y_nxt  = sum_y[PosW:1];
        vel_x_nxt  = next_speed(vel_x_r, sum_x[PosW:1], pos_x_r);
        vel_y_nxt  = next_speed(vel_y_r, sum_y[PosW:1], pos_y_r);
        found_nxt  = (frame.code == cfg.found_code);
        beat_nxt   = frame.beat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= tfpf_pkg::ST_IDLE;
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      vel_x_r  <= '0;
      vel_y_r  <= '0;
      found_r  <= 1'b0;
      beat_r   <= '0;
    end else if (advance) begin
      status_r <= status_nxt;
      pos_x_r  <= pos_x_nxt;
      pos_y_r  <= pos_y_nxt;
      vel_x_r  <= vel_x_nxt;
      vel_y_r  <= vel_y_nxt;
      found_r  <= found_nxt;
      beat_r   <= beat_nxt;
    end
  end

  always_comb begin
    result.status = status_r;
    result.pos_x  = pos_x_r;
    result.pos_y  = pos_y_r;
    result.vel_x  = vel_x_r;
    result.vel_y  = vel_y_r;
    result.found  = found_r;
    result.beat   = beat_r;
  end

endmodule

// ===== sv/target_frame_parser_filter_core.sv =====
// Top level: stream handshake, configuration registers and result register.
//
//  channel  | direction | payload
//  in_*     | slave     | tdata[7:0] rx_byte
//  out_*    | master    | tuser[1:0] frame_status, tdata pos/vel/found/heartbeat
//  cfg_*    | write     | cfg_index selects register, cfg_wdata value
//
// One byte per cycle sustained while out_tready is high; each byte gives one result,
// offered once it has passed the input register and the result state registers. The
// rate is set by the single pass from the input register through the divide-by-five
// multiply. Synchronous reset restores defaults and clears frame and filter state.
// A stalled result holds its payload; one more byte waits in the input register,
// then in_tready drops until the result is taken.
module target_frame_parser_filter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [9:0] pos_x, [19:10] pos_y, [31:20] vel_x,
                                  // [43:32] vel_y, [44] target_found,
                                  // [52:45] heartbeat, [55:53] zero
  output logic [1:0]  out_tuser,  // [1:0] frame_status
  input  logic        cfg_wen,
  input  logic [tfpf_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [tfpf_pkg::CfgDataW-1:0]  cfg_wdata
);

  tfpf_pkg::cfg_t    cfg_r;
  tfpf_pkg::frame_t  frame;
  tfpf_pkg::result_t result;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  logic       advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_byte <= tfpf_pkg::HeaderReset;
      cfg_r.tail_byte   <= tfpf_pkg::TailReset;
      cfg_r.found_code  <= tfpf_pkg::FoundReset;
      cfg_r.x_limit     <= tfpf_pkg::XLimitReset;
      cfg_r.y_limit     <= tfpf_pkg::YLimitReset;
    end else if (cfg_wen) begin
      case (tfpf_pkg::cfg_reg_t'(cfg_index))
        tfpf_pkg::REG_HEADER:  cfg_r.header_byte <= cfg_wdata[7:0];
        tfpf_pkg::REG_TAIL:    cfg_r.tail_byte   <= cfg_wdata[7:0];
        tfpf_pkg::REG_FOUND:   cfg_r.found_code  <= cfg_wdata[7:0];
        tfpf_pkg::REG_X_LIMIT: cfg_r.x_limit     <= cfg_wdata;
        tfpf_pkg::REG_Y_LIMIT: cfg_r.y_limit     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  tfpf_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .byte_in (in_byte_r),
    .cfg     (cfg_r),
    .frame   (frame)
  );

  tfpf_filter u_filter (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .frame   (frame),
    .cfg     (cfg_r),
    .result  (result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = result.status;
  assign out_tdata  = {3'b000, result.beat, result.found, result.vel_y, result.vel_x,
                       result.pos_y, result.pos_x};

`ifndef SYNTHESIS
  a_state_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_tuser == tfpf_pkg::ST_ACCEPT) || (out_tdata == $past(out_tdata)))
    else $error("filter state changed without an accepted frame");

  a_result_from_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_valid_r))
    else $error("result appeared without a held input byte");

  a_drain_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_tvalid) |=> out_tvalid)
    else $error("held input byte did not move into the result register");
`endif

endmodule
